// ----- design/frip_pkg.sv -----
// Package for the frame rotate / flip / invert block.
// Shared widths, register and transform codes, controller state and command types.
// No dependencies.
package frip_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 9;
  localparam int XF_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int PRM_W      = 13;

  localparam logic [XF_W-1:0] XF_NONE   = 3'd0;
  localparam logic [XF_W-1:0] XF_ROT90  = 3'd1;
  localparam logic [XF_W-1:0] XF_ROT180 = 3'd2;
  localparam logic [XF_W-1:0] XF_ROT270 = 3'd3;
  localparam logic [XF_W-1:0] XF_MIRROR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXVAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;

  localparam logic REQ_READ      = 1'b1;
  localparam logic STS_OK        = 1'b0;
  localparam logic STS_NOT_READY = 1'b1;

  localparam logic [PIX_W-1:0] RST_MAXVAL = 8'd255;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 9'd20;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 9'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DECIDE,
    ST_FETCH,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic write_px;
    logic nack;
    logic advance;
    logic fetch;
    logic deliver;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic loaded;
  } sts_t;

  // zero reads as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [PRM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (PRM_W'(v) > lim) begin
      res = lim[DIM_W-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- design/frip_ram.sv -----
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module frip_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/frip_ctrl.sv -----
// Controller state machine for the frame rotate / flip / invert block.
// Depends on frip_pkg (state_t, cmd_t, sts_t).
module frip_ctrl
  import frip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_PREP;
      end
      ST_PREP:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.is_read && sts.loaded) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FETCH:  state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_PREP:   cmd.prep = 1'b1;
      ST_DECIDE: begin
        cmd.write_px = !sts.is_read;
        cmd.nack     = sts.is_read && !sts.loaded;
        cmd.advance  = sts.is_read && sts.loaded;
      end
      ST_FETCH:  cmd.fetch = 1'b1;
      ST_OUT:    cmd.deliver = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

// ----- design/frip_dp.sv -----
// Datapath: configuration registers, frame store, counters, address and output logic.
// Depends on frip_pkg and frip_ram.
module frip_dp
  import frip_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  in_req_type,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_end_of_row,
  output logic                  out_end_of_frame,
  output logic                  out_status
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WC_W    = $clog2(STORE_DEPTH + 1);
  localparam int TOT_W   = 2 * DIM_W;
  localparam int CMP_W   = (TOT_W > WC_W) ? TOT_W : WC_W;
  localparam int DIM_CAP = (1 << DIM_W) - 1;
  localparam int W_LIM   = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
  localparam int H_LIM   = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;
  localparam int MAX_DIM = (W_LIM > H_LIM) ? W_LIM : H_LIM;
  localparam int RC_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = DIM_W + 1;

  // configuration
  logic [XF_W-1:0]  transform_r;
  logic             invert_r;
  logic [PIX_W-1:0] maxval_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  // transaction payload and per-transaction working values
  logic             req_r;
  logic [PIX_W-1:0] pix_in_r;
  logic [DIM_W-1:0] w_r, rows_r, cols_r;
  logic [TOT_W-1:0] total_r;
  logic [AW-1:0]    sr_r, sc_r, addr_r;
  logic             eor_r, eof_r;

  // frame state
  logic [WC_W-1:0]  wc_r, wc_nxt;
  logic             full_r, full_nxt;
  logic [RC_W-1:0]  row_r, row_nxt;
  logic [RC_W-1:0]  col_r, col_nxt;

  // output
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_eor_r, out_eof_r, out_status_r;

  logic [DIM_W-1:0] w_cl, h_cl;
  logic [XF_W-1:0]  mode;
  logic             turned;
  logic [AW-1:0]    h_a, w_a, r_a, c_a, sr_c, sc_c, w_ext;
  logic             loaded;
  logic [WC_W-1:0]  wc_inc;
  logic             eor_c, eof_c;
  logic [PIX_W-1:0] rd_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transform_r <= XF_NONE;
      invert_r    <= 1'b0;
      maxval_r    <= RST_MAXVAL;
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANSFORM: transform_r <= cfg_data[XF_W-1:0];
        CFG_INVERT:    invert_r    <= cfg_data[0];
        CFG_MAXVAL:    maxval_r    <= cfg_data[PIX_W-1:0];
        CFG_WIDTH:     width_r     <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:    height_r    <= cfg_data[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  assign w_cl   = clamp_dim(width_r, PRM_W'(MAX_WIDTH));
  assign h_cl   = clamp_dim(height_r, PRM_W'(MAX_HEIGHT));
  assign mode   = (transform_r > XF_MIRROR) ? XF_NONE : transform_r;
  assign turned = (mode == XF_ROT90) || (mode == XF_ROT270);

  // source coordinates, taken modulo 2**AW (the address width)
  assign h_a = AW'(h_cl);
  assign w_a = AW'(w_cl);
  assign r_a = AW'(row_r);
  assign c_a = AW'(col_r);

  always_comb begin
    case (mode)
      XF_ROT90: begin
        sr_c = h_a - AW'(1) - c_a;
        sc_c = r_a;
      end
      XF_ROT180: begin
        sr_c = h_a - AW'(1) - r_a;
        sc_c = w_a - AW'(1) - c_a;
      end
      XF_ROT270: begin
        sr_c = c_a;
        sc_c = w_a - AW'(1) - r_a;
      end
      XF_MIRROR: begin
        sr_c = r_a;
        sc_c = w_a - AW'(1) - c_a;
      end
      default: begin
        sr_c = r_a;
        sc_c = c_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_req_type;
      pix_in_r <= in_pixel_in;
    end
    if (cmd.prep) begin
      w_r     <= w_cl;
      total_r <= TOT_W'(w_cl) * TOT_W'(h_cl);
      rows_r  <= turned ? w_cl : h_cl;
      cols_r  <= turned ? h_cl : w_cl;
      sr_r    <= sr_c;
      sc_r    <= sc_c;
    end
    if (cmd.advance) begin
      addr_r <= AW'(sr_r * w_ext) + sc_r;
      eor_r  <= eor_c;
      eof_r  <= eof_c;
    end
  end

  assign w_ext   = AW'(w_r);
  assign loaded  = full_r || (CMP_W'(wc_r) >= CMP_W'(total_r));
  assign wc_inc  = wc_r + WC_W'(1);
  assign eor_c   = (CNT_W'(col_r) + CNT_W'(1)) >= CNT_W'(cols_r);
  assign eof_c   = eor_c && ((CNT_W'(row_r) + CNT_W'(1)) >= CNT_W'(rows_r));

  assign sts.is_read = (req_r == REQ_READ);
  assign sts.loaded  = loaded;

  always_comb begin
    wc_nxt        = wc_r;
    full_nxt      = full_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = cmd.nack || cmd.deliver;
    if (cmd.write_px && !loaded) begin
      wc_nxt   = wc_inc;
      full_nxt = CMP_W'(wc_inc) >= CMP_W'(total_r);
    end
    if (cmd.advance) begin
      if (eof_c) begin
        row_nxt  = '0;
        col_nxt  = '0;
        wc_nxt   = '0;
        full_nxt = 1'b0;
      end else if (eor_c) begin
        col_nxt = '0;
        row_nxt = row_r + RC_W'(1);
      end else begin
        col_nxt = col_r + RC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      full_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wc_r        <= wc_nxt;
      full_r      <= full_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  frip_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.write_px && !loaded),
    .wr_addr (AW'(wc_r)),
    .wr_data (pix_in_r),
    .rd_en   (cmd.fetch),
    .rd_addr (addr_r),
    .rd_data (rd_pix)
  );

  always_ff @(posedge clk) begin
    if (cmd.nack) begin
      out_pix_r    <= '0;
      out_eor_r    <= 1'b0;
      out_eof_r    <= 1'b0;
      out_status_r <= STS_NOT_READY;
    end else if (cmd.deliver) begin
      out_pix_r    <= invert_r ? (maxval_r - rd_pix) : rd_pix;
      out_eor_r    <= eor_r;
      out_eof_r    <= eof_r;
      out_status_r <= STS_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pix_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;
  assign out_status       = out_status_r;

  // a result strobe is never followed directly by another
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(wc_r) <= CMP_W'(STORE_DEPTH))
    else $error("write count beyond store depth");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && eof_c) |=> (row_r == '0 && col_r == '0 && wc_r == '0 && !full_r))
    else $error("frame state not cleared after last pixel");

  a_fetch_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> $past(cmd.advance))
    else $error("store read without address computation");

endmodule

// ----- design/frame_rotate_flip_invert.sv -----
// Top level of the frame rotate / flip / invert block.
// Depends on frip_pkg, frip_ctrl, frip_dp (which holds frip_ram).
//
//  channel   ports                                           handshake
//  input     in_req_type, in_pixel_in                        start & !busy
//  result    out_pixel_out, out_end_of_row,                  out_valid, one cycle,
//            out_end_of_frame, out_status                    no back-pressure
//  config    cfg_index, cfg_data                             cfg_we
//
// A write transaction keeps busy high through the PREP and DECIDE states; a read of an
// unloaded frame has its result registered from DECIDE, and a loaded read passes through
// PREP for coordinates, DECIDE for the multiply-add address, FETCH for the registered
// store read and OUT for inversion into the output register.
// rst_n is synchronous; the frame store is not cleared.
// The result is held for one cycle only; busy is already low in that cycle.
module frame_rotate_flip_invert
  import frip_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_end_of_row,
  output logic                  out_end_of_frame,
  output logic                  out_status
);

  cmd_t cmd;
  sts_t sts;

  frip_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  frip_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_pixel_in      (in_pixel_in),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .out_status       (out_status)
  );

endmodule

// ----- test/frame_rotate_flip_invert_check.sv -----
`timescale 1ns / 100ps
// Scoreboard for frame_rotate_flip_invert: watches the command, result and register ports,
// predicts every read transaction and compares results field by field.
// Depends on frip_pkg.
module frame_rotate_flip_invert_check
  import frip_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_req_type,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_valid,
  input  logic [PIX_W-1:0]      out_pixel_out,
  input  logic                  out_end_of_row,
  input  logic                  out_end_of_frame,
  input  logic                  out_status,
  output int                    errors,
  output int                    pending,
  output int                    frames,
  output int                    results
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eor;
    logic             eof;
    logic             status;
  } frame_px_t;

  logic [PIX_W-1:0] store [STORE_DEPTH];
  int unsigned      wr_count;
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic             frame_full;

  logic [XF_W-1:0]  xf;
  logic             inv_en;
  logic [PIX_W-1:0] max_val;
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;

  frame_px_t expected_px[$];

  function automatic int unsigned clamp_size(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_pixels();
    return clamp_size(img_w, MAX_WIDTH) * clamp_size(img_h, MAX_HEIGHT);
  endfunction

  // next pixel of the transformed image; advances the read position
  function automatic frame_px_t read_next();
    int unsigned     w, h, rows, cols, r, c, sr, sc;
    logic [XF_W-1:0] mode;
    logic            turned;
    frame_px_t       res;
    w = clamp_size(img_w, MAX_WIDTH);
    h = clamp_size(img_h, MAX_HEIGHT);
    mode = (xf <= XF_MIRROR) ? xf : XF_NONE;
    turned = (mode == XF_ROT90) || (mode == XF_ROT270);
    rows = turned ? w : h;
    cols = turned ? h : w;
    r = row_pos;
    c = col_pos;
    case (mode)
      XF_ROT90: begin
        sr = h - 1 - c;
        sc = r;
      end
      XF_ROT180: begin
        sr = h - 1 - r;
        sc = w - 1 - c;
      end
      XF_ROT270: begin
        sr = c;
        sc = w - 1 - r;
      end
      XF_MIRROR: begin
        sr = r;
        sc = w - 1 - c;
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
    res.pixel = store[SA_W'((sr * w + sc) % STORE_DEPTH)];
    if (inv_en) res.pixel = max_val - res.pixel;
    res.eor = (c + 1 >= cols);
    res.eof = res.eor && (r + 1 >= rows);
    res.status = STS_OK;
    if (res.eof) begin
      row_pos = 0;
      col_pos = 0;
      wr_count = 0;
      frame_full = 1'b0;
    end else if (res.eor) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    frame_px_t got, want;
    logic      loaded;
    if (!rst_n) begin
      wr_count = 0;
      row_pos = 0;
      col_pos = 0;
      frame_full = 1'b0;
      xf = XF_NONE;
      inv_en = 1'b0;
      max_val = RST_MAXVAL;
      img_w = RST_WIDTH;
      img_h = RST_HEIGHT;
      expected_px.delete();
      errors = 0;
      frames = 0;
      results = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_pixel_out, out_end_of_row, out_end_of_frame, out_status};
        results++;
        if (got.eof) frames++;
        if (expected_px.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result pixel %0d eor %0b eof %0b status %0b", $time,
                     got.pixel, got.eor, got.eof, got.status);
        end else begin
          want = expected_px.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch, expected pixel %0d eor %0b eof %0b status %0b,",
                        " got pixel %0d eor %0b eof %0b status %0b"}, $time,
                       want.pixel, want.eor, want.eof, want.status,
                       got.pixel, got.eor, got.eof, got.status);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_TRANSFORM: xf = cfg_data[XF_W-1:0];
          CFG_INVERT:    inv_en = cfg_data[0];
          CFG_MAXVAL:    max_val = cfg_data[PIX_W-1:0];
          CFG_WIDTH:     img_w = cfg_data[DIM_W-1:0];
          CFG_HEIGHT:    img_h = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        loaded = frame_full || (wr_count >= frame_pixels());
        if (in_req_type == REQ_READ) begin
          if (loaded) expected_px.push_back(read_next());
          else expected_px.push_back('{'0, 1'b0, 1'b0, STS_NOT_READY});
        end else if (!loaded) begin
          store[SA_W'(wr_count % STORE_DEPTH)] = in_pixel_in;
          wr_count++;
          if (wr_count >= frame_pixels()) frame_full = 1'b1;
        end
      end
      pending <= expected_px.size();
    end
  end

endmodule

// ----- test/frame_rotate_flip_invert_test.sv -----
`timescale 1ns / 100ps
// Top of the frame_rotate_flip_invert testbench: clock, reset, frame stimulus and verdict.
// Depends on frip_pkg, the block and frame_rotate_flip_invert_check.
module frame_rotate_flip_invert_test;
  import frip_pkg::*;

  localparam int   LIMIT     = 1_000_000;
  localparam int   ITEMS     = 1150;
  localparam logic REQ_WRITE = ~REQ_READ;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_req_type = 1'b0;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_end_of_row;
  logic                  out_end_of_frame;
  logic                  out_status;

  int errors, pending, frames, results;
  int cycles = 0;

  // frame bookkeeping on the stimulus side
  int unsigned cur_w = 32'(RST_WIDTH);
  int unsigned cur_h = 32'(RST_HEIGHT);
  int unsigned tot = 400;
  int unsigned wr_n = 0;
  int unsigned rd_n = 0;
  logic        full = 1'b0;
  int          n_items = 0;
  logic        no_gaps = 1'b0;

  frame_rotate_flip_invert dut (.*);
  frame_rotate_flip_invert_check chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("frame_rotate_flip_invert test failed");
      $finish;
    end
  end

  function automatic int unsigned dim_of(input int unsigned v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic pause();
    int n;
    if (no_gaps || $urandom_range(4) < 2) return;
    n = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send(input logic kind, input logic [PIX_W-1:0] pix);
    start <= 1'b1;
    in_req_type <= kind;
    in_pixel_in <= pix;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == REQ_WRITE) begin
      if (!full) begin
        wr_n++;
        n_items++;
        if (wr_n >= tot) full = 1'b1;
      end
    end else begin
      n_items++;
      if (full) begin
        rd_n++;
        if (rd_n >= tot) begin
          rd_n = 0;
          wr_n = 0;
          full = 1'b0;
        end
      end
    end
    pause();
  endtask

  // hold off until every expected result is back and the block is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic resize(input int unsigned w, input int unsigned h);
    cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
    cur_w = w;
    cur_h = h;
    tot = dim_of(w) * dim_of(h);
    if (!full && wr_n >= tot) full = 1'b1;
  endtask

  task automatic set_frame(input logic [XF_W-1:0] xf, input logic inv,
                           input logic [PIX_W-1:0] mv, input int unsigned w,
                           input int unsigned h);
    logic [CFG_DATA_W-1:0] spare;
    // unused upper data bits are sometimes set
    spare = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) : '0;
    cfg_write(CFG_TRANSFORM, {spare[CFG_DATA_W-1:XF_W], xf});
    cfg_write(CFG_INVERT, {spare[CFG_DATA_W-1:1], inv});
    cfg_write(CFG_MAXVAL, {spare[CFG_DATA_W-1:PIX_W], mv});
    resize(w, h);
  endtask

  initial begin
    logic [XF_W-1:0]  xf;
    logic [PIX_W-1:0] mv;
    int unsigned      w, h;
    int               cut_at, swap_at;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: not-ready read, extremes, ignored write, saturation, shrink mid-load
    send(REQ_READ, '0);
    settle();
    set_frame(XF_NONE, 1'b0, 8'd255, 2, 2);
    send(REQ_READ, 8'hFF);
    send(REQ_WRITE, 8'h00);
    send(REQ_WRITE, 8'hFF);
    send(REQ_WRITE, 8'h55);
    send(REQ_WRITE, 8'hAA);
    send(REQ_WRITE, 8'h3C);
    repeat (4) send(REQ_READ, '0);
    settle();
    set_frame(3'd7, 1'b1, 8'd0, 0, 3);
    send(REQ_WRITE, 8'h01);
    send(REQ_WRITE, 8'hFF);
    send(REQ_WRITE, 8'h80);
    repeat (3) send(REQ_READ, '0);
    settle();
    set_frame(XF_ROT90, 1'b1, 8'd255, 3, 2);
    repeat (4) send(REQ_WRITE, PIX_W'($urandom));
    settle();
    resize(3, 1);
    repeat (3) send(REQ_READ, '0);

    while (n_items < ITEMS) begin
      settle();
      xf = ($urandom_range(9) == 0) ? XF_W'($urandom_range(7, 5)) : XF_W'($urandom_range(4));
      case ($urandom_range(5))
        0: mv = 8'd0;
        1: mv = 8'd255;
        2: mv = 8'd1;
        default: mv = PIX_W'($urandom);
      endcase
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(3))
          0: begin w = 256; h = $urandom_range(2, 1); end
          1: begin w = $urandom_range(2, 1); h = 256; end
          2: begin w = $urandom_range(511, 257); h = 1; end
          default: begin w = 1; h = $urandom_range(511, 257); end
        endcase
      end else if ($urandom_range(3) == 0) begin
        w = $urandom_range(6, 1);
        h = w;
      end else begin
        w = $urandom_range(8);
        h = $urandom_range(8);
      end
      set_frame(xf, 1'($urandom_range(1)), mv, w, h);
      no_gaps = ($urandom_range(3) == 0);

      cut_at = (tot > 1 && $urandom_range(7) == 0) ? $urandom_range(tot - 1, 1) : -1;
      while (!full) begin
        if (int'(wr_n) == cut_at) begin
          settle();
          resize($urandom_range(8, 1), $urandom_range(8, 1));
          cut_at = -1;
        end else begin
          if ($urandom_range(19) == 0) send(REQ_READ, PIX_W'($urandom));
          send(REQ_WRITE, PIX_W'($urandom));
        end
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) send(REQ_WRITE, PIX_W'($urandom));

      swap_at = (tot > 1 && $urandom_range(4) == 0) ? $urandom_range(tot - 1, 1) : -1;
      while (full) begin
        if (int'(rd_n) == swap_at) begin
          settle();
          cfg_write(CFG_INVERT, CFG_DATA_W'($urandom_range(1)));
          cfg_write(CFG_MAXVAL, CFG_DATA_W'($urandom_range(255)));
          // square frames keep every address in range under any transform
          if (dim_of(cur_w) == dim_of(cur_h))
            cfg_write(CFG_TRANSFORM, CFG_DATA_W'($urandom_range(7)));
          swap_at = -1;
        end
        send(REQ_READ, PIX_W'($urandom));
      end
    end

    no_gaps = 1'b0;
    settle();
    $display("Sent %0d transactions; %0d results checked over %0d complete output frames.",
             n_items, results, frames);
    if (errors == 0) begin
      $display("frame_rotate_flip_invert test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("frame_rotate_flip_invert test failed");
    end
    $finish;
  end

endmodule

// ----- frame_rotate_flip_invert.f -----
design/frip_pkg.sv
design/frip_ram.sv
design/frip_ctrl.sv
design/frip_dp.sv
design/frame_rotate_flip_invert.sv
test/frame_rotate_flip_invert_check.sv
test/frame_rotate_flip_invert_test.sv
